// ----- hw/rtl/sdf_pkg.sv -----
`default_nettype none

package sdf_pkg;

   // Number format and widths.
   localparam int FRAC_BITS    = 16;
   localparam int DIST_EPSILON = 7;
   localparam int DATA_W       = 32;
   localparam int DIFF_W       = DATA_W + 1;          // exact difference of two inputs
   localparam int RAD_W        = 2 * DIFF_W;          // squared distance
   localparam int ROOT_W       = DIFF_W;              // distance
   localparam int SQ_STEPS     = RAD_W / 2;           // one root bit per stage
   localparam int SQ_REM_W     = ROOT_W + 2;          // partial remainder of the root
   localparam int Q_W          = FRAC_BITS + 1;       // unit vector magnitude, at most 1.0
   localparam int DIV_STEPS    = Q_W;                 // one quotient bit per stage
   localparam int DIV_REM_W    = ROOT_W;              // divider remainder stays below the divisor
   localparam int CSR_IDX_W    = 8;

   localparam logic [Q_W-1:0]    UNIT_ONE = Q_W'(1) << FRAC_BITS;
   localparam logic [DATA_W-1:0] SAT_POS  = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_NEG  = 32'h8000_0000;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_STIFFNESS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING   = 8'd1;

   // Data that rides along the square root pipeline.
   typedef struct packed {
      logic [DIFF_W-1:0]        mag_x;
      logic [DIFF_W-1:0]        mag_y;
      logic                     neg_x;
      logic                     neg_y;
      logic signed [DIFF_W-1:0] rvx;
      logic signed [DIFF_W-1:0] rvy;
      logic [DATA_W-1:0]        rest;
   } sq_side_type;

   // Data that rides along the divider pipeline.
   typedef struct packed {
      logic                     neg_x;
      logic                     neg_y;
      logic signed [DIFF_W-1:0] rvx;
      logic signed [DIFF_W-1:0] rvy;
      logic [DATA_W-1:0]        rest;
      logic [ROOT_W-1:0]        span;
      logic                     coincide;
   } dv_side_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sdf_isqrt.sv -----
`default_nettype none

// Pipelined integer square root, one root bit resolved per stage.
module sdf_isqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [sdf_pkg::RAD_W-1:0]   in_rad,
   input  wire sdf_pkg::sq_side_type        in_side,
   output logic                             out_valid,
   output logic [sdf_pkg::ROOT_W-1:0]       out_root,
   output sdf_pkg::sq_side_type             out_side
);
   import sdf_pkg::*;

   logic                vld_ff  [SQ_STEPS];
   logic [RAD_W-1:0]    rad_ff  [SQ_STEPS];
   logic [ROOT_W-1:0]   root_ff [SQ_STEPS];
   logic [SQ_REM_W-1:0] rem_ff  [SQ_STEPS];
   sq_side_type         side_ff [SQ_STEPS];

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
      logic                vld_cur;
      logic [RAD_W-1:0]    rad_cur;
      logic [ROOT_W-1:0]   root_cur;
      logic [SQ_REM_W-1:0] rem_cur;
      sq_side_type         side_cur;
      logic [SQ_REM_W+1:0] rem_sh;
      logic [SQ_REM_W+1:0] trial;
      logic [SQ_REM_W+1:0] diff;
      logic                take;
      logic [ROOT_W-1:0]   root_in;
      logic [SQ_REM_W-1:0] rem_in;
      logic [RAD_W-1:0]    rad_in;

      // Stage inputs come from the ports or from the previous stage.
      if (i == 0) begin : g_first
         assign vld_cur  = in_valid;
         assign rad_cur  = in_rad;
         assign root_cur = '0;
         assign rem_cur  = '0;
         assign side_cur = in_side;
      end else begin : g_next
         assign vld_cur  = vld_ff[i-1];
         assign rad_cur  = rad_ff[i-1];
         assign root_cur = root_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      // Bring down two radicand bits and try the next root bit.
      always_comb begin
         rem_sh  = {rem_cur, rad_cur[RAD_W-1 -: 2]};
         trial   = {{(SQ_REM_W-ROOT_W){1'b0}}, root_cur, 2'b01};
         diff    = rem_sh - trial;
         take    = (rem_sh >= trial);
         root_in = {root_cur[ROOT_W-2:0], take};
         rem_in  = take ? diff[SQ_REM_W-1:0] : rem_sh[SQ_REM_W-1:0];
         rad_in  = {rad_cur[RAD_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[i]  <= rad_in;
         root_ff[i] <= root_in;
         rem_ff[i]  <= rem_in;
         side_ff[i] <= side_cur;
      end
   end

   assign out_valid = vld_ff[SQ_STEPS-1];
   assign out_root  = root_ff[SQ_STEPS-1];
   assign out_side  = side_ff[SQ_STEPS-1];

`ifndef SYNTH
   // The remainder never exceeds twice the root found so far.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SQ_STEPS-1] |->
         (rem_ff[SQ_STEPS-1] <= {root_ff[SQ_STEPS-1], 1'b0}))
      else $error("square root remainder out of range");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/sdf_udiv.sv -----
`default_nettype none

// Two-lane pipelined restoring divider for the unit vector, one quotient
// bit per stage. The dividend is the component magnitude shifted up by
// the fraction width and the divisor is the distance.
module sdf_udiv (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [sdf_pkg::DIFF_W-1:0]  in_num_x,
   input  wire logic [sdf_pkg::DIFF_W-1:0]  in_num_y,
   input  wire sdf_pkg::dv_side_type        in_side,
   output logic                             out_valid,
   output logic [sdf_pkg::Q_W-1:0]          out_quo_x,
   output logic [sdf_pkg::Q_W-1:0]          out_quo_y,
   output sdf_pkg::dv_side_type             out_side
);
   import sdf_pkg::*;

   localparam int NLANE = 2;

   logic                 vld_ff  [DIV_STEPS];
   dv_side_type          side_ff [DIV_STEPS];
   logic [DIV_REM_W-1:0] rem_ff  [NLANE][DIV_STEPS];
   logic [Q_W-1:0]       quo_ff  [NLANE][DIV_STEPS];
   logic [DIFF_W-1:0]    num_lane [NLANE];

   assign num_lane[0] = in_num_x;
   assign num_lane[1] = in_num_y;

   // Valid bits and side data shared by both lanes.
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (i == 0) begin
            vld_ff[i] <= in_valid;
         end else begin
            vld_ff[i] <= vld_ff[(i == 0) ? 0 : i-1];
         end
      end

      always_ff @(posedge clock) begin
         side_ff[i] <= (i == 0) ? in_side : side_ff[(i == 0) ? 0 : i-1];
      end
   end

   for (genvar l = 0; l < NLANE; l++) begin : g_lane
      for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
         logic [DIV_REM_W-1:0] rem_cur;
         logic [Q_W-1:0]       quo_cur;
         logic                 bit_cur;
         logic [DIV_REM_W-1:0] den;
         logic [DIV_REM_W:0]   rem_sh;
         logic [DIV_REM_W:0]   diff;
         logic                 take;

         // The quotient fits in Q_W bits, so the upper dividend bits start
         // as the remainder and only the last bits are brought down.
         if (i == 0) begin : g_first
            assign rem_cur = DIV_REM_W'(num_lane[l][DIFF_W-1:1]);
            assign quo_cur = '0;
            assign bit_cur = num_lane[l][0];
            assign den     = in_side.span;
         end else begin : g_next
            assign rem_cur = rem_ff[l][i-1];
            assign quo_cur = quo_ff[l][i-1];
            assign bit_cur = 1'b0;
            assign den     = side_ff[i-1].span;
         end

         always_comb begin
            rem_sh = {rem_cur, bit_cur};
            diff   = rem_sh - {1'b0, den};
            take   = (rem_sh >= {1'b0, den});
         end

         always_ff @(posedge clock) begin
            rem_ff[l][i] <= take ? diff[DIV_REM_W-1:0] : rem_sh[DIV_REM_W-1:0];
            quo_ff[l][i] <= {quo_cur[Q_W-2:0], take};
         end
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_quo_x = quo_ff[0][DIV_STEPS-1];
   assign out_quo_y = quo_ff[1][DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];

`ifndef SYNTH
   // A unit vector component never exceeds one.
   a_quo_x_unit: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_side.coincide) |-> (out_quo_x <= UNIT_ONE))
      else $error("unit vector x above one");

   a_quo_y_unit: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_side.coincide) |-> (out_quo_y <= UNIT_ONE))
      else $error("unit vector y above one");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/spring_damper_force_2d.sv -----
`default_nettype none

// Damped spring force between two 2D point masses in signed Q16.16. The
// block is a fixed pipeline that takes one item in every cycle (busy never
// rises) and strobes rsp_valid for exactly one cycle per accepted item;
// results come out in the order the items went in, and the receiver cannot
// hold them off. The pipeline is made of the square root, which resolves
// one of 33 root bits per stage, followed by the unit vector divider at
// one of 17 quotient bits per stage, plus four input stages and eight
// stages of multiply, accumulate and saturation. The stiffness and
// damping registers are written through the csr_ port, which is always
// ready; they should be written only when no item is in flight.
module spring_damper_force_2d (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic signed [31:0]              req_pos_a_x,
   input  wire logic signed [31:0]              req_pos_a_y,
   input  wire logic signed [31:0]              req_vel_a_x,
   input  wire logic signed [31:0]              req_vel_a_y,
   input  wire logic signed [31:0]              req_pos_b_x,
   input  wire logic signed [31:0]              req_pos_b_y,
   input  wire logic signed [31:0]              req_vel_b_x,
   input  wire logic signed [31:0]              req_vel_b_y,
   input  wire logic [31:0]                     req_rest_length,
   output logic                                 rsp_valid,
   output logic signed [31:0]                   rsp_force_x,
   output logic signed [31:0]                   rsp_force_y,
   output logic                                 rsp_points_coincide,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [sdf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [31:0]                     csr_wdata
);
   import sdf_pkg::*;

   localparam int LATENCY = 4 + SQ_STEPS + DIV_STEPS + 8;
   localparam int PROD_W  = DIFF_W + Q_W + 1;     // velocity times unit component
   localparam int DOT_W   = PROD_W + 1;
   localparam int STR_W   = DIFF_W + 1;           // magnitude of the stretch
   localparam int CLS_W   = DOT_W - 1 - FRAC_BITS;
   localparam int SPR_W   = STR_W + DATA_W - FRAC_BITS;
   localparam int DMP_W   = CLS_W + DATA_W - FRAC_BITS;
   localparam int GAIN_W  = DMP_W + 2;
   localparam int FRC_W   = GAIN_W + Q_W - FRAC_BITS;

   // Unit vector data kept to the end of the pipeline.
   typedef struct packed {
      logic [Q_W-1:0] qx;
      logic [Q_W-1:0] qy;
      logic           nx;
      logic           ny;
      logic           coincide;
   } keep_type;

   logic [DATA_W-1:0] stiff_ff;
   logic [DATA_W-1:0] damp_ff;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= '0;
         damp_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STIFFNESS: stiff_ff <= csr_wdata;
            CSR_DAMPING:   damp_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline never stalls, so an item is taken in every cycle.
   assign busy = 1'b0;

   logic                     a_vld_ff;
   logic signed [DIFF_W-1:0] a_dx_ff, a_dy_ff, a_rvx_ff, a_rvy_ff;
   logic [DATA_W-1:0]        a_rest_ff;
   logic                     b_vld_ff;
   sq_side_type              b_side_ff;
   logic                     c_vld_ff;
   sq_side_type              c_side_ff;
   logic [RAD_W-1:0]         c_sqx_ff, c_sqy_ff;
   logic                     d_vld_ff;
   sq_side_type              d_side_ff;
   logic [RAD_W-1:0]         d_rad_ff;

   // Stage A: exact differences of positions and velocities.
   always_ff @(posedge clock) begin
      a_dx_ff   <= DIFF_W'(req_pos_a_x) - DIFF_W'(req_pos_b_x);
      a_dy_ff   <= DIFF_W'(req_pos_a_y) - DIFF_W'(req_pos_b_y);
      a_rvx_ff  <= DIFF_W'(req_vel_a_x) - DIFF_W'(req_vel_b_x);
      a_rvy_ff  <= DIFF_W'(req_vel_a_y) - DIFF_W'(req_vel_b_y);
      a_rest_ff <= req_rest_length;
   end

   // Stage B: magnitudes and signs of the position difference.
   always_ff @(posedge clock) begin
      b_side_ff.neg_x <= a_dx_ff[DIFF_W-1];
      b_side_ff.neg_y <= a_dy_ff[DIFF_W-1];
      b_side_ff.mag_x <= a_dx_ff[DIFF_W-1] ? DIFF_W'(-a_dx_ff) : DIFF_W'(a_dx_ff);
      b_side_ff.mag_y <= a_dy_ff[DIFF_W-1] ? DIFF_W'(-a_dy_ff) : DIFF_W'(a_dy_ff);
      b_side_ff.rvx   <= a_rvx_ff;
      b_side_ff.rvy   <= a_rvy_ff;
      b_side_ff.rest  <= a_rest_ff;
   end

   // Stage C: squares; stage D: squared distance.
   always_ff @(posedge clock) begin
      c_sqx_ff  <= b_side_ff.mag_x * b_side_ff.mag_x;
      c_sqy_ff  <= b_side_ff.mag_y * b_side_ff.mag_y;
      c_side_ff <= b_side_ff;
      d_rad_ff  <= c_sqx_ff + c_sqy_ff;
      d_side_ff <= c_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   // Distance.
   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;
   sq_side_type       sq_side;
   dv_side_type       dv_side_in;

   sdf_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_vld_ff),
      .in_rad    (d_rad_ff),
      .in_side   (d_side_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      dv_side_in.neg_x    = sq_side.neg_x;
      dv_side_in.neg_y    = sq_side.neg_y;
      dv_side_in.rvx      = sq_side.rvx;
      dv_side_in.rvy      = sq_side.rvy;
      dv_side_in.rest     = sq_side.rest;
      dv_side_in.span     = sq_root;
      dv_side_in.coincide = (sq_root <= ROOT_W'(DIST_EPSILON));
   end

   // Unit vector magnitudes.
   logic           dv_vld;
   logic [Q_W-1:0] dv_qx, dv_qy;
   dv_side_type    dv_side;

   sdf_udiv u_udiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_vld),
      .in_num_x  (sq_side.mag_x),
      .in_num_y  (sq_side.mag_y),
      .in_side   (dv_side_in),
      .out_valid (dv_vld),
      .out_quo_x (dv_qx),
      .out_quo_y (dv_qy),
      .out_side  (dv_side)
   );

   logic                     e_vld_ff, f_vld_ff, g_vld_ff, h_vld_ff;
   logic                     i_vld_ff, j_vld_ff, k_vld_ff;
   keep_type                 e_keep_ff, f_keep_ff, g_keep_ff, h_keep_ff;
   keep_type                 i_keep_ff, j_keep_ff, k_keep_ff;
   logic signed [Q_W:0]      e_ux_ff, e_uy_ff;
   logic signed [DIFF_W-1:0] e_rvx_ff, e_rvy_ff;
   logic [DATA_W-1:0]        e_rest_ff;
   logic [ROOT_W-1:0]        e_dist_ff;
   logic signed [PROD_W-1:0] f_px_ff, f_py_ff;
   logic [STR_W-1:0]         f_str_mag_ff;
   logic                     f_str_neg_ff;
   logic [SPR_W-1:0]         g_spr_mag_ff, h_spr_mag_ff;
   logic                     g_spr_neg_ff, h_spr_neg_ff;
   logic [CLS_W-1:0]         g_cls_mag_ff;
   logic                     g_cls_neg_ff;
   logic [DMP_W-1:0]         h_dmp_mag_ff;
   logic                     h_dmp_neg_ff;
   logic signed [GAIN_W-1:0] i_gain_ff;
   logic [GAIN_W-1:0]        j_gmag_ff;
   logic                     j_gneg_ff;
   logic [FRC_W-1:0]         k_fx_mag_ff, k_fy_mag_ff;
   logic                     k_fx_neg_ff, k_fy_neg_ff;

   logic signed [STR_W:0]       stretch;
   logic signed [DOT_W-1:0]     dot;
   logic [DOT_W-1:0]            dot_mag;
   logic [STR_W+DATA_W-1:0]     spr_prod;
   logic [CLS_W+DATA_W-1:0]     dmp_prod;
   logic signed [GAIN_W-1:0]    spr_s, dmp_s;
   logic [GAIN_W+Q_W-1:0]       fx_prod, fy_prod;

   // Tail arithmetic between stages.
   always_comb begin
      stretch  = (STR_W+1)'(e_rest_ff) - (STR_W+1)'(e_dist_ff);
      dot      = DOT_W'(f_px_ff) + DOT_W'(f_py_ff);
      dot_mag  = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
      spr_prod = f_str_mag_ff * stiff_ff;
      dmp_prod = g_cls_mag_ff * damp_ff;
      spr_s    = h_spr_neg_ff ? -$signed(GAIN_W'(h_spr_mag_ff))
                              :  $signed(GAIN_W'(h_spr_mag_ff));
      dmp_s    = h_dmp_neg_ff ? -$signed(GAIN_W'(h_dmp_mag_ff))
                              :  $signed(GAIN_W'(h_dmp_mag_ff));
      fx_prod  = j_gmag_ff * j_keep_ff.qx;
      fy_prod  = j_gmag_ff * j_keep_ff.qy;
   end

   // Stages E to K: unit vector, projections, gain and force magnitude.
   always_ff @(posedge clock) begin
      // E: signed unit vector.
      e_keep_ff.qx       <= dv_qx;
      e_keep_ff.qy       <= dv_qy;
      e_keep_ff.nx       <= dv_side.neg_x;
      e_keep_ff.ny       <= dv_side.neg_y;
      e_keep_ff.coincide <= dv_side.coincide;
      e_ux_ff   <= dv_side.neg_x ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
      e_uy_ff   <= dv_side.neg_y ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
      e_rvx_ff  <= dv_side.rvx;
      e_rvy_ff  <= dv_side.rvy;
      e_rest_ff <= dv_side.rest;
      e_dist_ff <= dv_side.span;
      // F: velocity projections and stretch.
      f_keep_ff    <= e_keep_ff;
      f_px_ff      <= e_rvx_ff * e_ux_ff;
      f_py_ff      <= e_rvy_ff * e_uy_ff;
      f_str_neg_ff <= stretch[STR_W];
      f_str_mag_ff <= stretch[STR_W] ? STR_W'(-stretch) : STR_W'(stretch);
      // G: closing speed and spring term.
      g_keep_ff    <= f_keep_ff;
      g_cls_neg_ff <= dot[DOT_W-1];
      g_cls_mag_ff <= dot_mag[DOT_W-2:FRAC_BITS];
      g_spr_neg_ff <= f_str_neg_ff;
      g_spr_mag_ff <= spr_prod[STR_W+DATA_W-1:FRAC_BITS];
      // H: damping term.
      h_keep_ff    <= g_keep_ff;
      h_spr_neg_ff <= g_spr_neg_ff;
      h_spr_mag_ff <= g_spr_mag_ff;
      h_dmp_neg_ff <= g_cls_neg_ff;
      h_dmp_mag_ff <= dmp_prod[CLS_W+DATA_W-1:FRAC_BITS];
      // I: scalar gain.
      i_keep_ff <= h_keep_ff;
      i_gain_ff <= spr_s - dmp_s;
      // J: gain magnitude.
      j_keep_ff <= i_keep_ff;
      j_gneg_ff <= i_gain_ff[GAIN_W-1];
      j_gmag_ff <= i_gain_ff[GAIN_W-1] ? GAIN_W'(-i_gain_ff) : GAIN_W'(i_gain_ff);
      // K: force magnitudes.
      k_keep_ff   <= j_keep_ff;
      k_fx_neg_ff <= j_gneg_ff ^ j_keep_ff.nx;
      k_fy_neg_ff <= j_gneg_ff ^ j_keep_ff.ny;
      k_fx_mag_ff <= fx_prod[GAIN_W+Q_W-1:FRAC_BITS];
      k_fy_mag_ff <= fy_prod[GAIN_W+Q_W-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
         i_vld_ff <= 1'b0;
         j_vld_ff <= 1'b0;
         k_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= dv_vld;
         f_vld_ff <= e_vld_ff;
         g_vld_ff <= f_vld_ff;
         h_vld_ff <= g_vld_ff;
         i_vld_ff <= h_vld_ff;
         j_vld_ff <= i_vld_ff;
         k_vld_ff <= j_vld_ff;
      end
   end

   // Stage L: saturation to 32 bits and the result register.
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_fx_ff, rsp_fy_ff, rsp_fx_in, rsp_fy_in;
   logic              rsp_coin_ff;

   function automatic logic [DATA_W-1:0] sat_force(input logic [FRC_W-1:0] m,
                                                   input logic neg);
      logic [DATA_W-1:0] r;
      if (neg) begin
         r = (m > FRC_W'(SAT_NEG)) ? SAT_NEG : DATA_W'(-m);
      end else begin
         r = (m > FRC_W'(SAT_POS)) ? SAT_POS : m[DATA_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      rsp_fx_in = k_keep_ff.coincide ? '0 : sat_force(k_fx_mag_ff, k_fx_neg_ff);
      rsp_fy_in = k_keep_ff.coincide ? '0 : sat_force(k_fy_mag_ff, k_fy_neg_ff);
   end

   always_ff @(posedge clock) begin
      rsp_fx_ff   <= rsp_fx_in;
      rsp_fy_ff   <= rsp_fy_in;
      rsp_coin_ff <= k_keep_ff.coincide;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= k_vld_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_force_x         = rsp_fx_ff;
   assign rsp_force_y         = rsp_fy_ff;
   assign rsp_points_coincide = rsp_coin_ff;

`ifndef SYNTH
   // Coincident points always give a zero force.
   a_coincide_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_points_coincide) |-> (rsp_force_x == 0 && rsp_force_y == 0))
      else $error("nonzero force on coincident points");

   // Every result strobe stems from an item accepted a fixed time earlier.
   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching item");

   // A stiffness write lands in its register.
   a_csr_stiff: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $past(csr_valid && csr_ready && csr_index == CSR_STIFFNESS))
         |-> (stiff_ff == $past(csr_wdata)))
      else $error("stiffness write lost");
`endif

endmodule

`default_nettype wire
